[rtl/core/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// Page allocator package
// Types, field widths, status codes and register indexes that the page-run
// first-fit allocator shares between its files.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int NUM_PAGES_DEF = 1024;

   localparam int PAGE_W     = 10;
   localparam int COUNT_W    = 11;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [0:0] OP_ALLOC = 1'b0;
   localparam logic [0:0] OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FIT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REGION  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNALLOC = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OFF     = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FIT    = 1'd1;

   typedef struct packed {
      logic [0:0]         opcode;
      logic [COUNT_W-1:0] page_count;
      logic [PAGE_W-1:0]  page_index;
   } pfa_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   start_page;
      logic [COUNT_W-1:0]  freed_pages;
   } pfa_rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] region_start_page;
      logic              first_fit_enabled;
   } pfa_cfg_type;

endpackage

[rtl/core/pfa_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pfa_engine.sv]
// ----------------------------------------------------------------------------
// Page allocator engine
// Sequencer that clears the mark memory after reset, scans it for free runs,
// writes run marks, clears freed runs and holds the result register.
// ----------------------------------------------------------------------------
module pfa_engine #(
   parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pfa_pkg::pfa_cfg_type                 cfg,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pfa_pkg::pfa_req_type                 req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pfa_pkg::pfa_rsp_type                 rsp_payload,
   output logic                                 mem_wr_en,
   output logic [$clog2(NUM_PAGES)-1:0]         mem_wr_addr,
   output logic [$clog2(NUM_PAGES+1)-1:0]       mem_wr_data,
   output logic                                 mem_rd_en,
   output logic [$clog2(NUM_PAGES)-1:0]         mem_rd_addr,
   input  logic [$clog2(NUM_PAGES+1)-1:0]       mem_rd_data
);

   import pfa_pkg::*;

   localparam int IDX_W  = $clog2(NUM_PAGES);
   localparam int MARK_W = $clog2(NUM_PAGES + 1);
   localparam int CW     = (MARK_W > COUNT_W) ? MARK_W : COUNT_W;
   localparam logic [CW-1:0] NUM_C  = CW'(NUM_PAGES);
   localparam logic [CW-1:0] LAST_C = CW'(NUM_PAGES - 1);
   localparam logic [CW-1:0] ONE_C  = CW'(1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_MARK  = 3'd3;
   localparam logic [2:0] S_FCHK  = 3'd4;
   localparam logic [2:0] S_FCLR  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] ip_ff, ip_in;
   logic [CW-1:0] ep_ff, ep_in;
   logic          rdv_ff, rdv_in;
   logic [CW-1:0] run_ff, run_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] q_ff, q_in;
   logic [CW-1:0] end_ff, end_in;
   pfa_rsp_type   res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pfa_rsp_type   rsp_data_ff, rsp_data_in;

   logic [CW-1:0] idx_ext;
   logic [CW-1:0] cnt_ext;
   logic [CW-1:0] start_ext;
   logic [CW-1:0] mark_ext;
   logic [CW-1:0] mark_bound;
   logic [CW-1:0] run_next;
   logic [CW-1:0] first_page;
   logic [CW-1:0] q_next;

   assign idx_ext    = CW'(req_payload.page_index);
   assign cnt_ext    = CW'(req_payload.page_count);
   assign start_ext  = CW'(cfg.region_start_page);
   assign mark_ext   = CW'(mem_rd_data);
   assign mark_bound = (mark_ext > NUM_C) ? NUM_C : mark_ext;
   assign run_next   = (mem_rd_data == '0) ? run_ff + ONE_C : '0;
   assign first_page = ep_ff + ONE_C - cnt_ff;
   assign q_next     = q_ff + ONE_C;

   always_comb begin
      state_in     = state_ff;
      ip_in        = ip_ff;
      ep_in        = ep_ff;
      rdv_in       = 1'b0;
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      end_in       = end_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ip_ff[IDX_W-1:0];
      mem_wr_en    = 1'b0;
      mem_wr_addr  = q_ff[IDX_W-1:0];
      mem_wr_data  = '0;
      req_ready    = (state_ff == S_IDLE);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            q_in      = q_next;
            if (q_ff == LAST_C) begin
               q_in     = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               if (req_payload.opcode == OP_ALLOC) begin
                  if (!cfg.first_fit_enabled) begin
                     res_in.status = ST_OFF;
                     state_in      = S_DONE;
                  end else if (cnt_ext == '0) begin
                     res_in.status = ST_RANGE;
                     state_in      = S_DONE;
                  end else if (start_ext >= NUM_C) begin
                     res_in.status = ST_NO_FIT;
                     state_in      = S_DONE;
                  end else begin
                     ip_in    = start_ext;
                     run_in   = '0;
                     cnt_in   = cnt_ext;
                     state_in = S_SCAN;
                  end
               end else begin
                  if (idx_ext >= NUM_C) begin
                     res_in.status = ST_RANGE;
                     state_in      = S_DONE;
                  end else if (idx_ext < start_ext) begin
                     res_in.status = ST_REGION;
                     state_in      = S_DONE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = idx_ext[IDX_W-1:0];
                     q_in        = idx_ext;
                     state_in    = S_FCHK;
                  end
               end
            end
         end
         S_SCAN: begin
            if (ip_ff < NUM_C) begin
               mem_rd_en = 1'b1;
               rdv_in    = 1'b1;
               ip_in     = ip_ff + ONE_C;
               ep_in     = ip_ff;
            end
            if (rdv_ff) begin
               run_in = run_next;
               if (run_next == cnt_ff) begin
                  q_in              = first_page;
                  end_in            = ep_ff + ONE_C;
                  res_in.start_page = PAGE_W'(first_page);
                  state_in          = S_MARK;
               end else if (ep_ff == LAST_C) begin
                  res_in.status = ST_NO_FIT;
                  state_in      = S_DONE;
               end
            end
         end
         S_MARK: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = end_ff[MARK_W-1:0];
            q_in        = q_next;
            if (q_next == end_ff) begin
               state_in = S_DONE;
            end
         end
         S_FCHK: begin
            if (mem_rd_data == '0) begin
               res_in.status = ST_UNALLOC;
               state_in      = S_DONE;
            end else begin
               end_in             = mark_bound;
               res_in.freed_pages = COUNT_W'(mark_bound - q_ff);
               state_in           = S_FCLR;
            end
         end
         S_FCLR: begin
            mem_wr_en = 1'b1;
            q_in      = q_next;
            if (q_next == end_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         q_ff         <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_ff         <= q_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ip_ff       <= ip_in;
      ep_ff       <= ep_in;
      run_ff      <= run_in;
      cnt_ff      <= cnt_in;
      end_ff      <= end_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

[rtl/core/page_run_first_fit_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Page-run first-fit allocator
// Keeps one end mark per page in a RAM and serves allocate and free beats
// one at a time, with a registered result beat.
// ----------------------------------------------------------------------------
// After reset the block sweeps the mark RAM to zero, one page per cycle,
// with req_ready low; configuration writes are taken during the sweep. An
// allocate beat is taken in idle, then the scan reads pages from
// region_start_page up to the end of the fitting run or the last page, the
// pages of the run are marked and the result is posted. A free beat reads
// the mark of its page, clears the pages up to that mark and posts the
// result. Beats refused on their fields go straight to posting the result.
// The mark RAM is read one page a cycle by the scan and written one page a
// cycle by the mark and clear passes. A new request beat is taken while a
// finished result beat still waits.
module page_run_first_fit_allocator_unit #(
   parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  pfa_pkg::pfa_req_type             req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output pfa_pkg::pfa_rsp_type             rsp_payload
);

   import pfa_pkg::*;

   localparam int IDX_W  = $clog2(NUM_PAGES);
   localparam int MARK_W = $clog2(NUM_PAGES + 1);

   pfa_cfg_type cfg_ff, cfg_in;

   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [MARK_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [MARK_W-1:0] mem_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REGION_START: cfg_in.region_start_page = csr_wdata[PAGE_W-1:0];
            CSR_FIRST_FIT:    cfg_in.first_fit_enabled = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.region_start_page <= '0;
         cfg_ff.first_fit_enabled <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfa_engine #(
      .NUM_PAGES (NUM_PAGES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   pfa_ram #(
      .WIDTH (MARK_W),
      .DEPTH (NUM_PAGES)
   ) u_marks (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

[rtl/core/pfa_checker.sv]
// ----------------------------------------------------------------------------
// Page allocator checker
// Port-level assertions for the page-run first-fit allocator, bound to the
// top level.
// ----------------------------------------------------------------------------
module pfa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input pfa_pkg::pfa_rsp_type rsp_payload
);

   import pfa_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!req_ready && !rsp_valid))
      else $error("Block is not quiet after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("Stalled result beat changed or dropped.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status <= ST_OFF))
      else $error("Result beat carries an undefined status.");

   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != ST_OK))
         |-> (rsp_payload.start_page == '0 && rsp_payload.freed_pages == '0))
      else $error("Refused beat carries a page or a count.");

endmodule

bind page_run_first_fit_allocator_unit pfa_checker u_checker (.*);

[tb/page_run_first_fit_allocator_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page-run first-fit allocator testbench
// Drives allocate and free beats through the request channel, keeps its own
// copy of the page mark heap to work out each result beat, and compares the
// result channel field by field. The run moves through several register
// settings and idle patterns, including a long result hold-off.
// ----------------------------------------------------------------------------
module page_run_first_fit_allocator_unit_test;
   import pfa_pkg::*;

   localparam int NUM_PAGES   = NUM_PAGES_DEF;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      int unsigned start_pg;
      int unsigned pages;
   } page_run_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   pfa_req_type           req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   pfa_rsp_type           rsp_payload;

   logic [COUNT_W-1:0] heap_marks [NUM_PAGES];
   logic [PAGE_W-1:0]  scan_base = '0;
   logic               fit_on = 1'b1;

   pfa_req_type  pending_reqs [$];
   pfa_rsp_type  expected_rsps [$];
   page_run_type live_runs [$];

   int unsigned sender_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        rsp_hold_req = 1'b0;
   int unsigned hold_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;

   page_run_first_fit_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic pfa_rsp_type predict_allocation(input int unsigned count);
      pfa_rsp_type outcome;
      int unsigned run_len;
      int unsigned run_start;
      outcome = '0;
      run_len = 0;
      if (!fit_on) begin
         outcome.status = ST_OFF;
      end else if (count == 0) begin
         outcome.status = ST_RANGE;
      end else begin
         outcome.status = ST_NO_FIT;
         for (int p = scan_base; p < NUM_PAGES && outcome.status == ST_NO_FIT; p++) begin
            if (heap_marks[p] == '0) run_len++;
            else run_len = 0;
            if (run_len == count) begin
               run_start = p + 1 - count;
               for (int q = run_start; q <= p; q++) heap_marks[q] = COUNT_W'(p + 1);
               outcome.status = ST_OK;
               outcome.start_page = PAGE_W'(run_start);
               live_runs.push_back('{start_pg: run_start, pages: count});
            end
         end
      end
      return outcome;
   endfunction

   function automatic pfa_rsp_type predict_release(input int unsigned index);
      pfa_rsp_type outcome;
      int unsigned end_mark;
      int unsigned cleared;
      outcome = '0;
      cleared = 0;
      if (index >= NUM_PAGES) begin
         outcome.status = ST_RANGE;
      end else if (index < scan_base) begin
         outcome.status = ST_REGION;
      end else if (heap_marks[index] == '0) begin
         outcome.status = ST_UNALLOC;
      end else begin
         end_mark = heap_marks[index];
         for (int q = index; q < end_mark && q < NUM_PAGES; q++) begin
            heap_marks[q] = '0;
            cleared++;
         end
         outcome.status = ST_OK;
         outcome.freed_pages = COUNT_W'(cleared);
      end
      return outcome;
   endfunction

   function automatic pfa_req_type make_alloc(input int unsigned count);
      pfa_req_type item;
      item.opcode = OP_ALLOC;
      item.page_count = COUNT_W'(count);
      item.page_index = PAGE_W'($urandom);
      return item;
   endfunction

   function automatic pfa_req_type make_free(input int unsigned index);
      pfa_req_type item;
      item.opcode = OP_FREE;
      item.page_count = COUNT_W'($urandom);
      item.page_index = PAGE_W'(index);
      return item;
   endfunction

   function automatic pfa_req_type random_request();
      pfa_req_type item;
      int unsigned pick;
      int unsigned size_pick;
      int unsigned k;
      page_run_type victim;
      pick = $urandom_range(99);
      size_pick = $urandom_range(99);
      if (pick < 10) begin
         item.opcode = 1'($urandom_range(1));
         item.page_count = COUNT_W'($urandom);
         item.page_index = PAGE_W'($urandom);
      end else if (pick < 55 && live_runs.size() != 0) begin
         k = $urandom_range(live_runs.size() - 1);
         victim = live_runs[k];
         live_runs.delete(k);
         if ($urandom_range(3) == 0)
            item = make_free(victim.start_pg + $urandom_range(victim.pages - 1));
         else
            item = make_free(victim.start_pg);
      end else if (size_pick < 70) begin
         item = make_alloc($urandom_range(16, 1));
      end else if (size_pick < 95) begin
         item = make_alloc($urandom_range(128, 17));
      end else if (size_pick < 99) begin
         item = make_alloc($urandom_range(NUM_PAGES - 1, 129));
      end else begin
         item = make_alloc(NUM_PAGES);
      end
      return item;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_REGION_START) scan_base = data;
      else fit_on = data[0];
   endtask

   task automatic wait_quiet();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic feed_random(input int unsigned count);
      repeat (count) begin
         while (pending_reqs.size() >= 4) @(negedge clock);
         pending_reqs.push_back(random_request());
      end
   endtask

   always @(posedge clock) begin : req_driver
      pfa_rsp_type outcome;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_payload.opcode == OP_ALLOC)
               outcome = predict_allocation(req_payload.page_count);
            else
               outcome = predict_release(req_payload.page_index);
            expected_rsps.push_back(outcome);
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_payload <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      pfa_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected beat status", rsp_payload.status, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", rsp_payload.status, want.status);
            if (rsp_payload.start_page !== want.start_page)
               report_mismatch("start_page", rsp_payload.start_page, want.start_page);
            if (rsp_payload.freed_pages !== want.freed_pages)
               report_mismatch("freed_pages", rsp_payload.freed_pages, want.freed_pages);
         end
      end
      if (rsp_hold_req) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      rsp_ready <= !rsp_hold_req && hold_left <= 1 && $urandom_range(99) >= rsp_stall_pct;
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      foreach (heap_marks[i]) heap_marks[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Whole-heap runs, a free inside a run and a free that crosses a reused run.
      pending_reqs.push_back(make_alloc(1));
      pending_reqs.push_back(make_alloc(0));
      pending_reqs.push_back(make_alloc(2047));
      pending_reqs.push_back(make_alloc(NUM_PAGES));
      pending_reqs.push_back(make_free(0));
      pending_reqs.push_back(make_free(0));
      pending_reqs.push_back(make_alloc(NUM_PAGES));
      pending_reqs.push_back(make_alloc(1));
      pending_reqs.push_back(make_free(NUM_PAGES - 1));
      pending_reqs.push_back(make_free(512));
      pending_reqs.push_back(make_free(0));
      pending_reqs.push_back(make_alloc(3));
      pending_reqs.push_back(make_alloc(4));
      pending_reqs.push_back(make_free(4));
      pending_reqs.push_back(make_alloc(2));
      pending_reqs.push_back(make_free(3));
      wait_quiet();

      write_register(CSR_REGION_START, 10'd1023);
      pending_reqs.push_back(make_free(0));
      pending_reqs.push_back(make_alloc(1));
      pending_reqs.push_back(make_alloc(2));
      pending_reqs.push_back(make_free(NUM_PAGES - 1));
      wait_quiet();

      write_register(CSR_FIRST_FIT, {9'($urandom), 1'b0});
      pending_reqs.push_back(make_alloc(1));
      pending_reqs.push_back(make_free(NUM_PAGES - 1));
      wait_quiet();

      write_register(CSR_FIRST_FIT, {9'($urandom), 1'b1});
      write_register(CSR_REGION_START, 10'd0);
      feed_random(60);
      wait_quiet();

      write_register(CSR_REGION_START, 10'd341);
      sender_idle_pct = 65;
      feed_random(60);
      wait_quiet();

      write_register(CSR_REGION_START, 10'd682);
      sender_idle_pct = 0;
      rsp_stall_pct = 65;
      feed_random(60);
      wait_quiet();

      write_register(CSR_FIRST_FIT, {9'($urandom), 1'b0});
      write_register(CSR_REGION_START, 10'd512);
      sender_idle_pct = 27;
      rsp_stall_pct = 27;
      feed_random(30);
      wait_quiet();

      write_register(CSR_FIRST_FIT, {9'($urandom), 1'b1});
      write_register(CSR_REGION_START, 10'd1023);
      feed_random(20);
      wait_quiet();

      write_register(CSR_REGION_START, 10'd0);
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      feed_random(15);
      @(negedge clock);
      rsp_hold_req = 1'b1;
      @(negedge clock);
      rsp_hold_req = 1'b0;
      feed_random(25);
      wait_quiet();
      sender_idle_pct = 27;
      rsp_stall_pct = 27;
      feed_random(20);
      wait_quiet();

      repeat (2 * NUM_PAGES + 16) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[page_run_first_fit_allocator_unit.f]
rtl/core/pfa_pkg.sv
rtl/core/pfa_ram.sv
rtl/core/pfa_engine.sv
rtl/core/page_run_first_fit_allocator_unit.sv
rtl/core/pfa_checker.sv
tb/page_run_first_fit_allocator_unit_test.sv
